// ===== hdl/bde_pkg.sv =====
package bde_pkg;

    localparam int BUTTON_COUNT_DEFAULT = 10;
    localparam int FIELD_WIDTH          = 10;
    localparam int MM_WIDTH             = 8;
    localparam int HOLD_WIDTH           = 16;
    localparam int CFG_INDEX_WIDTH      = 2;
    localparam int CFG_DATA_WIDTH       = 16;

    localparam logic [MM_WIDTH-1:0]   MM_THRESHOLD_RESET   = MM_WIDTH'(5);
    localparam logic [HOLD_WIDTH-1:0] HOLD_THRESHOLD_RESET = HOLD_WIDTH'(200);
    localparam logic [HOLD_WIDTH-1:0] HOLD_LIMIT_RESET     = HOLD_WIDTH'(200);
    localparam logic [MM_WIDTH-1:0]   MM_MAX               = '1;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_MISMATCH_THRESHOLD = 2'd0,
        REG_HOLD_THRESHOLD     = 2'd1,
        REG_HOLD_LIMIT         = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic                   scan_enable;
        logic [FIELD_WIDTH-1:0] raw_levels;
    } bde_in_t;

    typedef struct packed {
        logic [FIELD_WIDTH-1:0] clean_levels;
        logic [FIELD_WIDTH-1:0] press_mask;
        logic [FIELD_WIDTH-1:0] release_mask;
        logic [FIELD_WIDTH-1:0] hold_instant_mask;
        logic [FIELD_WIDTH-1:0] hold_continuous_mask;
    } bde_out_t;

    typedef struct packed {
        logic [MM_WIDTH-1:0]   mismatch_threshold;
        logic [HOLD_WIDTH-1:0] hold_threshold;
        logic [HOLD_WIDTH-1:0] hold_limit;
    } bde_cfg_t;

    typedef struct packed {
        logic clean;
        logic press;
        logic release_evt;
        logic hold_instant;
        logic hold_continuous;
    } lane_evt_t;

endpackage

// ===== hdl/button_debounce_event_detector.sv =====
// Debounces up to BUTTON_COUNT buttons (at most FIELD_WIDTH reported) and
// reports per-tick press, release, hold-instant and hold-continuous masks.
// One beat in gives one beat out; all buttons are handled by parallel lanes,
// so a tick is taken every cycle unless the input stalls, and its result is
// registered. The input stalls only while the output register is full and
// not being drained. Configuration writes take effect on the next cycle.
module button_debounce_event_detector #(
    parameter int BUTTON_COUNT = bde_pkg::BUTTON_COUNT_DEFAULT
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_write,
    input  logic [bde_pkg::CFG_INDEX_WIDTH-1:0]     cfg_index,
    input  logic [bde_pkg::CFG_DATA_WIDTH-1:0]      cfg_data,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  bde_pkg::bde_in_t                        in_data,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output bde_pkg::bde_out_t                       out_data
);
    import bde_pkg::*;

    bde_cfg_t                      cfg_reg, cfg_next;
    lane_evt_t [BUTTON_COUNT-1:0]  evt;
    logic                          take;
    logic                          step;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_MISMATCH_THRESHOLD: cfg_next.mismatch_threshold = cfg_data[MM_WIDTH-1:0];
                REG_HOLD_THRESHOLD:     cfg_next.hold_threshold     = cfg_data[HOLD_WIDTH-1:0];
                REG_HOLD_LIMIT:         cfg_next.hold_limit         = cfg_data[HOLD_WIDTH-1:0];
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mismatch_threshold <= MM_THRESHOLD_RESET;
            cfg_reg.hold_threshold     <= HOLD_THRESHOLD_RESET;
            cfg_reg.hold_limit         <= HOLD_LIMIT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign in_ready = ~out_valid | out_ready;
    assign take     = in_valid & in_ready;
    assign step     = take & in_data.scan_enable;

    for (genvar g = 0; g < BUTTON_COUNT; g++)
    begin : g_lane
        logic level;
        if (g < FIELD_WIDTH)
        begin : g_bit
            assign level = in_data.raw_levels[g];
        end
        else
        begin : g_none
            assign level = 1'b0;
        end

        bde_lane u_lane (
            .clk   (clk),
            .rst_n (rst_n),
            .step  (step),
            .level (level),
            .cfg   (cfg_reg),
            .evt   (evt[g])
        );
    end

    bde_merge #(
        .BUTTON_COUNT (BUTTON_COUNT)
    ) u_merge (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (take),
        .scan_enable (in_data.scan_enable),
        .evt         (evt),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data)
    );

endmodule

// ===== hdl/bde_lane.sv =====
module bde_lane (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic                level,
    input  bde_pkg::bde_cfg_t   cfg,
    output bde_pkg::lane_evt_t  evt
);
    import bde_pkg::*;

    logic                  acc_reg, acc_next;
    logic                  clean_reg, clean_next;
    logic [MM_WIDTH-1:0]   mm_reg, mm_next, mm_inc;
    logic [HOLD_WIDTH-1:0] stable_reg, stable_next, stable_inc;
    logic                  accept;

    always_comb
    begin
        mm_inc = mm_reg;
        if (level != acc_reg && mm_reg != MM_MAX)
        begin
            mm_inc = mm_reg + MM_WIDTH'(1);
        end
        accept = (mm_inc >= cfg.mismatch_threshold);
        stable_inc = stable_reg;
        if (stable_reg < cfg.hold_limit)
        begin
            stable_inc = stable_reg + HOLD_WIDTH'(1);
        end

        acc_next    = acc_reg;
        clean_next  = clean_reg;
        mm_next     = mm_reg;
        stable_next = stable_reg;
        if (step)
        begin
            if (accept)
            begin
                acc_next    = level;
                clean_next  = level;
                mm_next     = '0;
                stable_next = '0;
            end
            else
            begin
                mm_next     = mm_inc;
                stable_next = stable_inc;
            end
        end

        evt.clean           = accept ? level : clean_reg;
        evt.press           = accept & level;
        evt.release_evt     = accept & ~level;
        evt.hold_instant    = ~accept & clean_reg & (stable_inc >= cfg.hold_threshold);
        evt.hold_continuous = clean_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg    <= 1'b0;
            clean_reg  <= 1'b0;
            mm_reg     <= '0;
            stable_reg <= '0;
        end
        else
        begin
            acc_reg    <= acc_next;
            clean_reg  <= clean_next;
            mm_reg     <= mm_next;
            stable_reg <= stable_next;
        end
    end

endmodule

// ===== hdl/bde_merge.sv =====
module bde_merge #(
    parameter int BUTTON_COUNT = bde_pkg::BUTTON_COUNT_DEFAULT
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    take,
    input  logic                                    scan_enable,
    input  bde_pkg::lane_evt_t [BUTTON_COUNT-1:0]   evt,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output bde_pkg::bde_out_t                       out_data
);
    import bde_pkg::*;

    bde_out_t merged;
    bde_out_t data_reg, data_next;
    logic     valid_reg, valid_next;

    always_comb
    begin
        merged = '0;
        for (int i = 0; i < FIELD_WIDTH; i++)
        begin
            if (i < BUTTON_COUNT && scan_enable)
            begin
                merged.clean_levels[i]         = evt[i].clean;
                merged.press_mask[i]           = evt[i].press;
                merged.release_mask[i]         = evt[i].release_evt;
                merged.hold_instant_mask[i]    = evt[i].hold_instant;
                merged.hold_continuous_mask[i] = evt[i].hold_continuous;
            end
        end
    end

    always_comb
    begin
        data_next  = data_reg;
        valid_next = valid_reg & ~out_ready;
        if (take)
        begin
            data_next  = merged;
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    a_press_release_disjoint: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> ((data_reg.press_mask & data_reg.release_mask) == '0))
        else $error("press and release on same button");

    a_hold_instant_clean: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> ((data_reg.hold_instant_mask & ~data_reg.clean_levels) == '0))
        else $error("hold instant on released button");

    a_hold_instant_no_edge: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> ((data_reg.hold_instant_mask & data_reg.press_mask) == '0))
        else $error("hold instant with press");

    a_idle_tick_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (take && !scan_enable) |=> (valid_reg && data_reg == '0))
        else $error("disabled tick gave nonzero beat");

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import bde_pkg::*;

    localparam int                         BUTTONS       = FIELD_WIDTH;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_UNMAPPED  = 2'd3;
    localparam int                         DRAIN_CYCLES  = 3;
    localparam int                         TAIL_CYCLES   = 8;
    localparam int                         HOLD_OFF_LEN  = 300;
    localparam int                         QUIET_LIMIT   = 2000;
    localparam int                         PHASES        = 8;
    localparam int                         TICKS_PER_PHASE = 225;

    typedef enum logic {ROW_TICK, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t                  kind;
        bde_in_t                    beat;
        logic                       typed;
        bde_out_t                   want;
        logic [CFG_INDEX_WIDTH-1:0] idx;
        logic [CFG_DATA_WIDTH-1:0]  value;
    } row_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_write = 1'b0;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [CFG_DATA_WIDTH-1:0]  cfg_data = '0;
    logic                       in_valid = 1'b0;
    logic                       in_ready;
    bde_in_t                    in_data = '0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    bde_out_t                   out_data;

    logic                       cur_typed = 1'b0;
    bde_out_t                   cur_want = '0;

    // debounce state and registers as the block should hold them
    logic                       seen_raw   [BUTTONS];
    logic [MM_WIDTH-1:0]        miss_cnt   [BUTTONS];
    logic [HOLD_WIDTH-1:0]      stable_cnt [BUTTONS];
    logic                       clean_q    [BUTTONS];
    logic [MM_WIDTH-1:0]        mm_thr;
    logic [HOLD_WIDTH-1:0]      hold_thr;
    logic [HOLD_WIDTH-1:0]      hold_lim;

    bde_out_t                   pending_events[$];
    int                         errors = 0;
    int                         send_idle_pct = 0;
    int                         stall_pct = 0;
    logic                       hold_off_req = 1'b0;
    row_t                       script[$];

    button_debounce_event_detector u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #1 clk = ~clk;

    function automatic void clear_debounce();
        for (int b = 0; b < BUTTONS; b++)
        begin
            seen_raw[b]   = 1'b0;
            miss_cnt[b]   = '0;
            stable_cnt[b] = '0;
            clean_q[b]    = 1'b0;
        end
        mm_thr   = MM_THRESHOLD_RESET;
        hold_thr = HOLD_THRESHOLD_RESET;
        hold_lim = HOLD_LIMIT_RESET;
    endfunction

    function automatic void apply_reg(logic [CFG_INDEX_WIDTH-1:0] idx,
                                      logic [CFG_DATA_WIDTH-1:0] data);
        case (idx)
            REG_MISMATCH_THRESHOLD: mm_thr   = data[MM_WIDTH-1:0];
            REG_HOLD_THRESHOLD:     hold_thr = data[HOLD_WIDTH-1:0];
            REG_HOLD_LIMIT:         hold_lim = data[HOLD_WIDTH-1:0];
            default:                ;
        endcase
    endfunction

    function automatic bde_out_t debounce_tick(bde_in_t beat);
        bde_out_t ev;
        logic     lvl;
        ev = '0;
        if (beat.scan_enable)
        begin
            for (int b = 0; b < BUTTONS; b++)
            begin
                lvl = beat.raw_levels[b];
                if (lvl != seen_raw[b] && miss_cnt[b] != MM_MAX)
                    miss_cnt[b] = miss_cnt[b] + 1'b1;
                ev.hold_continuous_mask[b] = clean_q[b];
                if (miss_cnt[b] < mm_thr)
                begin
                    if (stable_cnt[b] < hold_lim)
                        stable_cnt[b] = stable_cnt[b] + 1'b1;
                    ev.hold_instant_mask[b] = (stable_cnt[b] >= hold_thr) && clean_q[b];
                end
                else
                begin
                    clean_q[b]    = lvl;
                    miss_cnt[b]   = '0;
                    stable_cnt[b] = '0;
                    seen_raw[b]   = lvl;
                    ev.press_mask[b]   = lvl;
                    ev.release_mask[b] = !lvl;
                end
                ev.clean_levels[b] = clean_q[b];
            end
        end
        return ev;
    endfunction

    function automatic void check_field(string name, logic [FIELD_WIDTH-1:0] want,
                                        logic [FIELD_WIDTH-1:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endfunction

    function automatic row_t tick_row(logic en, logic [FIELD_WIDTH-1:0] raw);
        row_t r;
        r = '{ROW_TICK, '0, 1'b0, '0, '0, '0};
        r.beat.scan_enable = en;
        r.beat.raw_levels  = raw;
        return r;
    endfunction

    function automatic row_t typed_row(logic en, logic [FIELD_WIDTH-1:0] raw, bde_out_t want);
        row_t r;
        r = tick_row(en, raw);
        r.typed = 1'b1;
        r.want  = want;
        return r;
    endfunction

    function automatic row_t cfg_row(logic [CFG_INDEX_WIDTH-1:0] idx,
                                     logic [CFG_DATA_WIDTH-1:0] value);
        row_t r;
        r = '{ROW_CFG, '0, 1'b0, '0, idx, value};
        return r;
    endfunction

    always @(posedge clk)
    begin
        bde_out_t want;
        if (rst_n)
        begin
            if (cfg_write)
                apply_reg(cfg_index, cfg_data);
            if (out_valid && out_ready)
            begin
                if (pending_events.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected beat, expected none, actual %h", $time, out_data);
                end
                else
                begin
                    want = pending_events.pop_front();
                    check_field("clean_levels", want.clean_levels, out_data.clean_levels);
                    check_field("press_mask", want.press_mask, out_data.press_mask);
                    check_field("release_mask", want.release_mask, out_data.release_mask);
                    check_field("hold_instant_mask", want.hold_instant_mask,
                                out_data.hold_instant_mask);
                    check_field("hold_continuous_mask", want.hold_continuous_mask,
                                out_data.hold_continuous_mask);
                end
            end
            if (in_valid && in_ready)
            begin
                want = debounce_tick(in_data);
                pending_events.push_back(cur_typed ? cur_want : want);
            end
        end
    end

    // sink side: random stalls plus one long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_OFF_LEN) @(posedge clk);
                hold_off_req = 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
                quiet = 0;
            else
                quiet++;
        end
        $display("Some tests failed");
        $finish;
    end

    task automatic send_tick(bde_in_t beat, logic typed, bde_out_t want);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        in_data   <= beat;
        cur_typed <= typed;
        cur_want  <= want;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_WIDTH-1:0] idx, logic [CFG_DATA_WIDTH-1:0] value);
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_events.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    initial
    begin
        bde_in_t                   beat;
        logic [FIELD_WIDTH-1:0]    pattern;
        logic [MM_WIDTH-1:0]       p_mm;
        logic [HOLD_WIDTH-1:0]     p_hold;
        logic [HOLD_WIDTH-1:0]     p_lim;

        clear_debounce();

        script.push_back(typed_row(1'b0, 10'h3FF, '0));
        script.push_back(typed_row(1'b1, 10'h000, '0));
        repeat (4) script.push_back(typed_row(1'b1, 10'h3FF, '0));
        script.push_back(typed_row(1'b1, 10'h3FF, bde_out_t'({10'h3FF, 10'h3FF, 10'h0, 10'h0, 10'h0})));
        script.push_back(typed_row(1'b1, 10'h3FF, bde_out_t'({10'h3FF, 10'h0, 10'h0, 10'h0, 10'h3FF})));
        script.push_back(typed_row(1'b0, 10'h000, '0));
        // zero threshold: every tick accepts, repeated acceptance fires again
        script.push_back(cfg_row(REG_MISMATCH_THRESHOLD, 16'h0000));
        script.push_back(typed_row(1'b1, 10'h2AA,
                                   bde_out_t'({10'h2AA, 10'h2AA, 10'h155, 10'h0, 10'h3FF})));
        script.push_back(typed_row(1'b1, 10'h2AA,
                                   bde_out_t'({10'h2AA, 10'h2AA, 10'h155, 10'h0, 10'h2AA})));
        script.push_back(cfg_row(REG_MISMATCH_THRESHOLD, 16'hFFFF));
        script.push_back(cfg_row(REG_HOLD_LIMIT, 16'd3));
        script.push_back(cfg_row(REG_HOLD_THRESHOLD, 16'd2));
        repeat (4) script.push_back(tick_row(1'b1, 10'h2AA));
        // limit lowered below the current stable count
        script.push_back(cfg_row(REG_HOLD_LIMIT, 16'd1));
        script.push_back(cfg_row(REG_HOLD_THRESHOLD, 16'd3));
        script.push_back(tick_row(1'b1, 10'h2AA));
        script.push_back(cfg_row(REG_UNMAPPED, 16'h0000));
        script.push_back(tick_row(1'b1, 10'h2AA));
        script.push_back(cfg_row(REG_HOLD_THRESHOLD, 16'hFFFF));
        script.push_back(cfg_row(REG_HOLD_LIMIT, 16'hFFFF));
        script.push_back(tick_row(1'b1, 10'h000));
        script.push_back(tick_row(1'b1, 10'h155));

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[k])
        begin
            if (script[k].kind == ROW_CFG)
                write_reg(script[k].idx, script[k].value);
            else
                send_tick(script[k].beat, script[k].typed, script[k].want);
        end

        pattern = '0;
        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0: begin p_mm = 8'd3;   p_hold = 16'd10;    p_lim = 16'd20;    end
                1: begin p_mm = 8'd0;   p_hold = 16'd0;     p_lim = 16'd0;     end
                2: begin p_mm = 8'd255; p_hold = 16'hFFFF;  p_lim = 16'hFFFF;  end
                3: begin p_mm = 8'd2;   p_hold = 16'd5;     p_lim = 16'd8;     end
                4: begin p_mm = 8'd4;   p_hold = 16'd30;    p_lim = 16'd30;    end
                5: begin p_mm = 8'd1;   p_hold = 16'd8;     p_lim = 16'd4;     end
                6: begin p_mm = 8'd6;   p_hold = 16'd20;    p_lim = 16'hFFFF;  end
                default:
                begin
                    p_mm   = MM_WIDTH'($urandom_range(10));
                    p_hold = HOLD_WIDTH'($urandom_range(50));
                    p_lim  = HOLD_WIDTH'($urandom_range(60));
                end
            endcase
            write_reg(REG_MISMATCH_THRESHOLD, {8'h00, p_mm});
            write_reg(REG_HOLD_THRESHOLD, p_hold);
            write_reg(REG_HOLD_LIMIT, p_lim);

            case (ph % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 50; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 50; end
                default: begin send_idle_pct = 29; stall_pct = 29; end
            endcase
            if (ph == 4)
                hold_off_req = 1'b1;

            for (int n = 0; n < TICKS_PER_PHASE; n++)
            begin
                // mostly held patterns with bounce, some noise
                if ($urandom_range(99) < 4)
                    pattern = FIELD_WIDTH'($urandom_range(1023));
                beat.scan_enable = ($urandom_range(99) >= 10);
                beat.raw_levels  = pattern;
                if ($urandom_range(99) < 15)
                    beat.raw_levels = beat.raw_levels ^ (10'd1 << $urandom_range(BUTTONS - 1));
                if ($urandom_range(99) < 5)
                    beat.raw_levels = FIELD_WIDTH'($urandom_range(1023));
                send_tick(beat, 1'b0, '0);
            end
        end

        in_valid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
